/* src/gdfw_pkg.sv */
`timescale 1ns / 1ps

package gdfw_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int MAX_EDGES    = 256;

    localparam int VTX_W   = $clog2(MAX_VERTICES);
    localparam int EADDR_W = $clog2(MAX_EDGES);
    localparam int EPTR_W  = EADDR_W + 1;
    localparam int DEPTH_W = VTX_W + 1;
    localparam int CNT_W   = 6;
    localparam int OP_W    = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [EPTR_W-1:0] NULL_EDGE = EPTR_W'(MAX_EDGES);

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_RUN    = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_CLEARED = 2'd3
    } t_status;

    typedef struct packed {
        logic [VTX_W-1:0]  target;
        logic [EPTR_W-1:0] link;
    } t_edge;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [VTX_W-1:0] src;
        logic [VTX_W-1:0] dst;
        logic             src_ok;
        logic             dst_ok;
    } t_cmd;

endpackage

/* src/graph_depth_first_walk.sv */
`timescale 1ns / 1ps

// Depth-first walk over a directed graph stored as adjacency lists.
// The input channel (i_valid, o_ready) carries one command per transfer: add an
// edge, run a walk from a start vertex, or clear the graph. The output channel
// (o_valid, i_ready) carries results: one status transfer for an add or a clear,
// and one transfer per visited vertex for a run, with o_last set on the final
// transfer of the command. A run from a bad start vertex gives one status.
// o_ready is high only while the sequencer is idle; each command is finished
// before the next is taken. An add or clear moves to S_RESP, which loads its
// status into the output register once that register is free and then returns
// to idle to take the next command. A run steps through S_LOOK and S_STEP for
// each edge that it examines, since every edge is fetched through the single
// read port of the edge memory and checked by one comparator.
// Results wait in an output register; when the receiver stalls, the walk pauses
// at the next vertex to be emitted and resumes once the register drains.
// APB address 0 holds vertex_count; the user must write it only while idle,
// as the block does not enforce this. Reset is synchronous, active low: the
// graph is empty, vertex_count is 32, no result pends; no clearing pass needed.

module graph_depth_first_walk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [gdfw_pkg::OP_W-1:0]      i_op,
    input  logic [gdfw_pkg::VTX_W-1:0]     i_src_vertex,
    input  logic [gdfw_pkg::VTX_W-1:0]     i_dest_vertex,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [gdfw_pkg::VTX_W-1:0]     o_vertex,
    output logic [1:0]                     o_status,
    output logic                           o_last,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gdfw_pkg::PADDR_W-1:0]   paddr,
    input  logic [gdfw_pkg::PDATA_W-1:0]   pwdata,
    output logic [gdfw_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    logic [gdfw_pkg::CNT_W-1:0] r_vertex_count;
    gdfw_pkg::t_cmd             w_cmd;
    gdfw_pkg::t_status          w_status;
    logic                       w_reg_sel;

    assign w_reg_sel = (paddr[2:2] == gdfw_pkg::REG_VERTEX_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= gdfw_pkg::CNT_W'(gdfw_pkg::MAX_VERTICES);
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_vertex_count <= pwdata[gdfw_pkg::CNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = w_reg_sel ? gdfw_pkg::PDATA_W'(r_vertex_count) : '0;

    always_comb begin
        w_cmd.op     = i_op;
        w_cmd.src    = i_src_vertex;
        w_cmd.dst    = i_dest_vertex;
        w_cmd.src_ok = gdfw_pkg::CNT_W'(i_src_vertex) < r_vertex_count;
        w_cmd.dst_ok = gdfw_pkg::CNT_W'(i_dest_vertex) < r_vertex_count;
    end

    gdfw_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_cmd       (w_cmd),
        .o_ready     (o_ready),
        .i_out_ready (i_ready),
        .o_valid     (o_valid),
        .o_vertex    (o_vertex),
        .o_status    (w_status),
        .o_last      (o_last)
    );

    assign o_status = w_status;

    a_busy_after_cmd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_op != gdfw_pkg::OP_UNUSED) |=> !o_ready)
        else $error("command transfer did not make the sequencer busy");

    a_status_only : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != 2'(gdfw_pkg::ST_OK)) |-> (o_vertex == '0) && o_last)
        else $error("status result carries a vertex or lacks the last flag");

    a_reset_quiet : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("result pending or sequencer busy after reset");

endmodule

/* src/gdfw_edge_mem.sv */
`timescale 1ns / 1ps

module gdfw_edge_mem (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [gdfw_pkg::EADDR_W-1:0] i_waddr,
    input  gdfw_pkg::t_edge              i_wdata,
    input  logic                         i_re,
    input  logic [gdfw_pkg::EADDR_W-1:0] i_raddr,
    output gdfw_pkg::t_edge              o_rdata
);

    gdfw_pkg::t_edge r_mem [gdfw_pkg::MAX_EDGES];
    gdfw_pkg::t_edge r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/gdfw_engine.sv */
`timescale 1ns / 1ps

module gdfw_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  gdfw_pkg::t_cmd             i_cmd,
    output logic                       o_ready,
    input  logic                       i_out_ready,
    output logic                       o_valid,
    output logic [gdfw_pkg::VTX_W-1:0] o_vertex,
    output gdfw_pkg::t_status          o_status,
    output logic                       o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESP,
        S_LOOK,
        S_STEP,
        S_DONE
    } t_state;

    t_state                             r_state;
    logic [gdfw_pkg::EPTR_W-1:0]        r_list_head [gdfw_pkg::MAX_VERTICES];
    logic [gdfw_pkg::EPTR_W-1:0]        r_stack [gdfw_pkg::MAX_VERTICES];
    logic [gdfw_pkg::DEPTH_W-1:0]       r_depth;
    logic [gdfw_pkg::EPTR_W-1:0]        r_edges_used;
    logic [gdfw_pkg::MAX_VERTICES-1:0]  r_visited;
    logic [gdfw_pkg::VTX_W-1:0]         r_pend;
    gdfw_pkg::t_status                  r_resp;
    logic                               r_out_valid;
    logic [gdfw_pkg::VTX_W-1:0]         r_out_vertex;
    gdfw_pkg::t_status                  r_out_status;
    logic                               r_out_last;

    logic                               w_out_free;
    logic                               w_emit;
    logic [gdfw_pkg::VTX_W-1:0]         w_top_idx;
    logic [gdfw_pkg::EPTR_W-1:0]        w_cursor;
    logic                               w_end;
    logic                               w_full;
    logic                               w_add_ok;
    logic [gdfw_pkg::VTX_W-1:0]         w_head_addr;
    logic [gdfw_pkg::EPTR_W-1:0]        w_head;
    gdfw_pkg::t_edge                    w_edge;
    gdfw_pkg::t_edge                    w_wdata;
    logic                               w_we;
    logic                               w_re;

    always_comb begin
        w_out_free  = !r_out_valid || i_out_ready;
        w_emit      = w_out_free && ((r_state == S_RESP) || (r_state == S_DONE)
                      || ((r_state == S_STEP) && !r_visited[w_edge.target]));
        w_top_idx   = gdfw_pkg::VTX_W'(r_depth - gdfw_pkg::DEPTH_W'(1));
        w_cursor    = r_stack[w_top_idx];
        // The one comparator tells a live edge from the end of a list.
        w_end       = w_cursor >= r_edges_used;
        w_full      = r_edges_used == gdfw_pkg::NULL_EDGE;
        w_add_ok    = i_cmd.src_ok && i_cmd.dst_ok && !w_full;
        w_head_addr = (r_state == S_IDLE) ? i_cmd.src : w_edge.target;
        w_head      = r_list_head[w_head_addr];
        w_wdata     = '{target: i_cmd.dst, link: w_head};
        w_we        = (r_state == S_IDLE) && i_valid && (i_cmd.op == gdfw_pkg::OP_ADD)
                      && w_add_ok;
        w_re        = (r_state == S_LOOK) && (r_depth != '0) && !w_end;
    end

    gdfw_edge_mem u_edge_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_edges_used[gdfw_pkg::EADDR_W-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_cursor[gdfw_pkg::EADDR_W-1:0]),
        .o_rdata (w_edge)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_depth      <= '0;
            r_edges_used <= '0;
            r_visited    <= '0;
            for (int i = 0; i < gdfw_pkg::MAX_VERTICES; i++) begin
                r_list_head[i] <= gdfw_pkg::NULL_EDGE;
            end
        end else begin
            r_out_valid <= w_emit || (r_out_valid && !i_out_ready);
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        unique case (i_cmd.op)
                            gdfw_pkg::OP_ADD: begin
                                if (!(i_cmd.src_ok && i_cmd.dst_ok)) begin
                                    r_resp <= gdfw_pkg::ST_RANGE;
                                end else if (w_full) begin
                                    r_resp <= gdfw_pkg::ST_FULL;
                                end else begin
                                    r_resp                  <= gdfw_pkg::ST_OK;
                                    r_list_head[i_cmd.src] <= r_edges_used;
                                    r_edges_used <= r_edges_used + gdfw_pkg::EPTR_W'(1);
                                end
                                r_state <= S_RESP;
                            end
                            gdfw_pkg::OP_RUN: begin
                                if (!i_cmd.src_ok) begin
                                    r_resp  <= gdfw_pkg::ST_RANGE;
                                    r_state <= S_RESP;
                                end else begin
                                    r_visited  <= gdfw_pkg::MAX_VERTICES'(1) << i_cmd.src;
                                    r_pend     <= i_cmd.src;
                                    r_stack[0] <= w_head;
                                    r_depth    <= gdfw_pkg::DEPTH_W'(1);
                                    r_state    <= S_LOOK;
                                end
                            end
                            gdfw_pkg::OP_CLEAR: begin
                                for (int i = 0; i < gdfw_pkg::MAX_VERTICES; i++) begin
                                    r_list_head[i] <= gdfw_pkg::NULL_EDGE;
                                end
                                r_edges_used <= '0;
                                r_visited    <= '0;
                                r_depth      <= '0;
                                r_resp       <= gdfw_pkg::ST_CLEARED;
                                r_state      <= S_RESP;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_RESP: begin
                    if (w_out_free) begin
                        r_out_vertex <= '0;
                        r_out_status <= r_resp;
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                S_LOOK: begin
                    if (r_depth == '0) begin
                        r_state <= S_DONE;
                    end else if (w_end) begin
                        r_depth <= r_depth - gdfw_pkg::DEPTH_W'(1);
                    end else begin
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (r_visited[w_edge.target]) begin
                        r_stack[w_top_idx] <= w_edge.link;
                        r_state            <= S_LOOK;
                    end else if (w_out_free) begin
                        // A new vertex: the one held back goes out, since it is
                        // now known not to be the last of the walk.
                        r_stack[w_top_idx]        <= w_edge.link;
                        r_visited[w_edge.target] <= 1'b1;
                        if (r_depth < gdfw_pkg::DEPTH_W'(gdfw_pkg::MAX_VERTICES)) begin
                            r_stack[r_depth[gdfw_pkg::VTX_W-1:0]] <= w_head;
                            r_depth <= r_depth + gdfw_pkg::DEPTH_W'(1);
                        end
                        r_out_vertex <= r_pend;
                        r_out_status <= gdfw_pkg::ST_OK;
                        r_out_last   <= 1'b0;
                        r_pend       <= w_edge.target;
                        r_state      <= S_LOOK;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_vertex <= r_pend;
                        r_out_status <= gdfw_pkg::ST_OK;
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_vertex = r_out_vertex;
    assign o_status = r_out_status;
    assign o_last   = r_out_last;

endmodule
